>>> hdl/sensor_frame_parser_checksum_core_defines.svh
// assertion macros for the sensor frame parser checksum core
// used by the port checker; no other dependencies
`ifndef SENSOR_FRAME_PARSER_CHECKSUM_CORE_DEFINES_SVH
`define SENSOR_FRAME_PARSER_CHECKSUM_CORE_DEFINES_SVH

// same-cycle implication
`define SFPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sfpc_pkg.sv
// shared types and constants of the sensor frame parser checksum core
// no dependencies
package sfpc_pkg;

	localparam int unsigned MAX_DATA_DEF = 32;
	localparam int unsigned DECODE_BYTES = 14;
	localparam int unsigned TDATA_W      = 112;
	localparam int unsigned TUSER_W      = 2;
	localparam int unsigned CFG_IDX_W    = 8;

	localparam logic [20:0] TEMP_OFFSET = 21'd500;
	localparam logic [20:0] SCALE       = 21'd10;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERIAL  = 8'd3;

	typedef enum logic [1:0] {
		ST_MEAS_OK  = 2'd0,
		ST_OTHER_OK = 2'd1,
		ST_SUM_ERR  = 2'd2,
		ST_LEN_ERR  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] head_byte;
		logic [7:0] cmd_measure;
		logic [7:0] cmd_version;
		logic [7:0] cmd_serial;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		head_byte:   8'd22,
		cmd_measure: 8'd31,
		cmd_version: 8'd30,
		cmd_serial:  8'd32
	};

	typedef struct packed {
		status_t     frame_status;
		logic [15:0] tvoc_ppb;
		logic [15:0] pm1_level;
		logic [15:0] pm25_level;
		logic [15:0] pm10_level;
		logic [20:0] temperature_scaled;
		logic [19:0] humidity_scaled;
	} res_t;

endpackage

>>> hdl/sensor_frame_parser_checksum_core.sv
// top level of the sensor frame parser checksum core
// depends on sfpc_pkg, sfpc_parser, sfpc_outbuf
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid/s_tready    received byte
// m_*       out        m_tvalid/m_tready    frame result
// cfg_*     in         cfg_valid/cfg_ready  register index and value
//
// one byte per cycle while s_tready is up; parser state updates on each byte taken
// a frame end or length error result is registered on m_* or in the skid entry
// s_tready drops only while both the result register and the skid entry are full
// reset clears parser state and loads the default register values, no clearing pass
module sensor_frame_parser_checksum_core #(
	parameter int unsigned MAX_DATA = sfpc_pkg::MAX_DATA_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,    // rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tvoc_ppb, pm1_level, pm25_level, pm10_level, temperature_scaled,
	// humidity_scaled, zero fill
	output logic [sfpc_pkg::TDATA_W-1:0]      m_tdata,
	output logic [sfpc_pkg::TUSER_W-1:0]      m_tuser,    // frame_status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sfpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);
	import sfpc_pkg::*;

	cfg_t cfg_q;
	logic s_fire;
	logic res_valid;
	res_t res;
	res_t out_res;

	assign cfg_ready = 1'b1;
	assign s_fire    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEAD:    cfg_q.head_byte   <= cfg_data;
				REG_MEASURE: cfg_q.cmd_measure <= cfg_data;
				REG_VERSION: cfg_q.cmd_version <= cfg_data;
				REG_SERIAL:  cfg_q.cmd_serial  <= cfg_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	sfpc_parser #(
		.MAX_DATA(MAX_DATA)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_fire),
		.req_byte (s_tdata),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	sfpc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (s_tready),
		.in_res   (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tuser = out_res.frame_status;
	assign m_tdata = {
		7'd0,
		out_res.humidity_scaled,
		out_res.temperature_scaled,
		out_res.pm10_level,
		out_res.pm25_level,
		out_res.pm1_level,
		out_res.tvoc_ppb
	};

endmodule

>>> hdl/sfpc_parser.sv
// frame parser: header hunt, length and command check, running sum, decode
// depends on sfpc_pkg
module sfpc_parser #(
	parameter int unsigned MAX_DATA = sfpc_pkg::MAX_DATA_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [7:0]        req_byte,
	input  sfpc_pkg::cfg_t    cfg,
	output logic              res_valid,
	output sfpc_pkg::res_t    res
);
	import sfpc_pkg::*;

	localparam int unsigned CW = $clog2(MAX_DATA + 1);
	localparam int unsigned IW = $clog2(DECODE_BYTES);
	localparam logic [8:0] LEN_MAX = 9'(MAX_DATA + 1);

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_CMD  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_SUM  = 5'b10000
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [7:0]      len_q, len_d;
	logic [7:0]      cmd_q, cmd_d;
	logic [CW-1:0]   count_q, count_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      data_q [DECODE_BYTES];
	logic [7:0]      vb [DECODE_BYTES];
	logic [20:0]     temp_ofs;
	logic [20:0]     temp_val;
	logic [19:0]     hum_val;
	logic            known_cmd;

	always_comb begin
		for (int i = 0; i < DECODE_BYTES; i++) begin
			vb[i] = (CW'(i) < count_q) ? data_q[i] : 8'd0;
		end
	end

	assign temp_ofs  = {5'd0, vb[10], vb[11]} - TEMP_OFFSET;
	assign temp_val  = 21'(temp_ofs * SCALE);
	assign hum_val   = 20'({5'd0, vb[12], vb[13]} * SCALE);
	assign known_cmd = (req_byte == cfg.cmd_measure) || (req_byte == cfg.cmd_version)
		|| (req_byte == cfg.cmd_serial);

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		count_d   = count_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res       = '0;
		if (req_valid) begin
			case (phase_q)
				PH_LEN: begin
					len_d = req_byte;
					sum_d = sum_q + req_byte;
					if (req_byte < 8'd2 || {1'b0, req_byte} > LEN_MAX) begin
						phase_d          = PH_HUNT;
						res_valid        = 1'b1;
						res.frame_status = ST_LEN_ERR;
					end else begin
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d = req_byte;
					sum_d = sum_q + req_byte;
					if (known_cmd) begin
						count_d = '0;
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_DATA: begin
					sum_d   = sum_q + req_byte;
					count_d = count_q + 1'b1;
					if (9'(count_d) + 9'd1 >= {1'b0, len_q}) begin
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					phase_d   = PH_HUNT;
					res_valid = 1'b1;
					if (req_byte != 8'(8'd0 - sum_q)) begin
						res.frame_status = ST_SUM_ERR;
					end else if (cmd_q == cfg.cmd_measure) begin
						res.frame_status       = ST_MEAS_OK;
						res.tvoc_ppb           = {vb[0], vb[1]};
						res.pm1_level          = {vb[4], vb[5]};
						res.pm25_level         = {vb[6], vb[7]};
						res.pm10_level         = {vb[8], vb[9]};
						res.temperature_scaled = temp_val;
						res.humidity_scaled    = hum_val;
					end else begin
						res.frame_status = ST_OTHER_OK;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					if (req_byte == cfg.head_byte) begin
						sum_d   = req_byte;
						count_d = '0;
						phase_d = PH_LEN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			cmd_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	// only the first DECODE_BYTES data bytes are kept, all the decoder reads
	always_ff @(posedge clk) begin
		if (req_valid && phase_q == PH_DATA && count_q < CW'(DECODE_BYTES)) begin
			data_q[count_q[IW-1:0]] <= req_byte;
		end
	end

endmodule

>>> hdl/sfpc_outbuf.sv
// result register with one skid entry behind it
// depends on sfpc_pkg
module sfpc_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sfpc_pkg::res_t in_res,
	output logic           out_valid,
	input  logic           out_ready,
	output sfpc_pkg::res_t out_res
);
	import sfpc_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_res_q;
	res_t skid_res_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (in_valid) begin
				out_res_q <= in_res;
			end
		end else if (in_valid) begin
			skid_res_q <= in_res;
		end
	end

endmodule

>>> hdl/sfpc_checker.sv
// port checker for the sensor frame parser checksum core, bound to the top level
// depends on sfpc_pkg and sensor_frame_parser_checksum_core_defines.svh
`include "sensor_frame_parser_checksum_core_defines.svh"

module sfpc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sfpc_pkg::TDATA_W-1:0]      m_tdata,
	input logic [sfpc_pkg::TUSER_W-1:0]      m_tuser
);
	import sfpc_pkg::*;

	`SFPC_ASSERT_NOW(a_err_fields_zero, clk, arst_n, m_tvalid && m_tuser != ST_MEAS_OK, m_tdata == '0, "non-measurement result carries nonzero fields")
	`SFPC_ASSERT_NOW(a_stall_needs_result, clk, arst_n, !s_tready, m_tvalid, "input stalled with no result pending")
	`SFPC_ASSERT_NEXT(a_drain_reopens, clk, arst_n, !s_tready && m_tready, s_tready, "input stays stalled after a result was taken")
	`SFPC_ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sensor_frame_parser_checksum_core sfpc_checker u_sfpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
